[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the block clock.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on i_clk, off while i_rst_n is low
`define KWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked on i_clk, checked during reset too
`define KWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/kwm_pkg.sv]
// ---------------------------------------------------------------------------
// kwm_pkg
// Types, codes and defaults shared by the k-way merge heap files.
// ---------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

    localparam int KWM_MAX_SOURCES = 32;
    localparam int KWM_CNT_W       = $clog2(KWM_MAX_SOURCES + 1);
    localparam int SRC_W           = 5;
    localparam int SOURCE_IDS      = 32;
    localparam int OP_W            = 2;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD   = 2'd1;
    localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd3;

    typedef logic [SRC_W-1:0] t_src;

    typedef struct packed {
        logic signed [31:0] ref_id;
        logic signed [31:0] position;
    } t_key;

endpackage

`default_nettype wire

[src/kwm_in_if.sv]
// ---------------------------------------------------------------------------
// kwm_in_if
// Input channel: one heap command per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface kwm_in_if;

    logic                        valid;
    logic                        ready;
    logic [kwm_pkg::OP_W-1:0]    op;
    logic [kwm_pkg::SRC_W-1:0]   source_id;
    logic signed [31:0]          ref_id;
    logic signed [31:0]          position;

    modport source (output valid, output op, output source_id, output ref_id,
                    output position, input ready);
    modport sink   (input valid, input op, input source_id, input ref_id,
                    input position, output ready);

endinterface

`default_nettype wire

[src/kwm_out_if.sv]
// ---------------------------------------------------------------------------
// kwm_out_if
// Output channel: heap top and fill state, one transaction per command.
// ---------------------------------------------------------------------------
`default_nettype none

interface kwm_out_if #(
    parameter int CNT_W = kwm_pkg::KWM_CNT_W
);

    logic                        valid;
    logic                        ready;
    logic [kwm_pkg::SRC_W-1:0]   min_source;
    logic signed [31:0]          min_ref_id;
    logic signed [31:0]          min_position;
    logic [CNT_W-1:0]            entry_count;
    logic                        is_empty;

    modport source (output valid, output min_source, output min_ref_id,
                    output min_position, output entry_count, output is_empty,
                    input ready);
    modport sink   (input valid, input min_source, input min_ref_id,
                    input min_position, input entry_count, input is_empty,
                    output ready);

endinterface

`default_nettype wire

[src/kwm_key_cmp.sv]
// ---------------------------------------------------------------------------
// kwm_key_cmp
// Shared key comparator: reference id first, then position, both signed.
// ---------------------------------------------------------------------------
`default_nettype none

module kwm_key_cmp (
    input  wire kwm_pkg::t_key i_a,
    input  wire kwm_pkg::t_key i_b,
    output logic               o_greater
);

    logic ref_gt;
    logic ref_eq;
    logic pos_gt;

    assign ref_gt    = (i_a.ref_id > i_b.ref_id);
    assign ref_eq    = (i_a.ref_id == i_b.ref_id);
    assign pos_gt    = (i_a.position > i_b.position);
    assign o_greater = ref_gt || (ref_eq && pos_gt);

endmodule

`default_nettype wire

[src/kway_merge_min_heap.sv]
// ---------------------------------------------------------------------------
// kway_merge_min_heap
// Binary min-heap of source numbers keyed by (reference id, position).
// ---------------------------------------------------------------------------
// One command is taken at a time; ready is high only while the sequencer is
// idle, and the result waits in an output register so the next command may
// enter before it is taken. A load, a build of fewer than two entries and an
// ignored command go from dispatch through TOP0 to TOP2, which raises the
// result valid as the sequencer returns to idle. Replace-top writes the new
// key of the top source and remove-top moves the last slot to the root; build
// loads each internal node from the last one back to the root. Each then sifts
// down, picking the smaller child where both exist and moving it up while the
// parent key is greater, before TOP0 to TOP2. A result not yet taken holds the
// sequencer in its last state. The step sequence is set by the single read
// port of the slot memory and of the key memory, and by the one key comparator
// shared by the child and parent compares of each level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kway_merge_min_heap #(
    parameter int MAX_SOURCES = kwm_pkg::KWM_MAX_SOURCES
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    kwm_in_if.sink    i_in,
    kwm_out_if.source o_out
);

    localparam int IDX_W = $clog2(MAX_SOURCES);
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam int CH_W  = IDX_W + 2;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_PLD0  = 4'd2;
    localparam logic [3:0] ST_PLD1  = 4'd3;
    localparam logic [3:0] ST_PLD2  = 4'd4;
    localparam logic [3:0] ST_REPL1 = 4'd5;
    localparam logic [3:0] ST_SL    = 4'd6;
    localparam logic [3:0] ST_SR    = 4'd7;
    localparam logic [3:0] ST_KL    = 4'd8;
    localparam logic [3:0] ST_KR    = 4'd9;
    localparam logic [3:0] ST_CP    = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;
    localparam logic [3:0] ST_TOP0  = 4'd12;
    localparam logic [3:0] ST_TOP1  = 4'd13;
    localparam logic [3:0] ST_TOP2  = 4'd14;

    // control
    logic [3:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_len,   n_len;
    logic [IDX_W-1:0]         r_node,  n_node;
    logic [IDX_W-1:0]         r_bld,   n_bld;
    logic                     r_ovalid, n_ovalid;

    // payload
    logic [kwm_pkg::OP_W-1:0] r_op,    n_op;
    kwm_pkg::t_src            r_src,   n_src;
    kwm_pkg::t_key            r_key,   n_key;
    kwm_pkg::t_src            r_psrc,  n_psrc;
    kwm_pkg::t_key            r_pkey,  n_pkey;
    kwm_pkg::t_src            r_lsrc,  n_lsrc;
    kwm_pkg::t_src            r_rsrc,  n_rsrc;
    kwm_pkg::t_src            r_csrc,  n_csrc;
    kwm_pkg::t_key            r_ckey,  n_ckey;
    logic [IDX_W-1:0]         r_cidx,  n_cidx;
    kwm_pkg::t_src            r_tsrc,  n_tsrc;
    kwm_pkg::t_src            r_omin,  n_omin;
    kwm_pkg::t_key            r_okey,  n_okey;
    logic [CNT_W-1:0]         r_ocnt,  n_ocnt;
    logic                     r_oempty, n_oempty;

    // memories
    kwm_pkg::t_src            r_slot_mem [MAX_SOURCES];
    kwm_pkg::t_src            r_slot_rd;
    logic                     slot_we;
    logic [IDX_W-1:0]         slot_waddr;
    kwm_pkg::t_src            slot_wdata;
    logic [IDX_W-1:0]         slot_raddr;

    kwm_pkg::t_key            r_key_mem [kwm_pkg::SOURCE_IDS];
    kwm_pkg::t_key            r_key_rd;
    logic                     key_we;
    kwm_pkg::t_src            key_waddr;
    kwm_pkg::t_key            key_wdata;
    kwm_pkg::t_src            key_raddr;

    // shared comparator
    kwm_pkg::t_key            cmp_a;
    kwm_pkg::t_key            cmp_b;
    logic                     cmp_gt;

    logic [CH_W-1:0]          lc;
    logic [CH_W-1:0]          rc;
    logic [CH_W-1:0]          len_ext;
    logic                     lc_in;
    logic                     rc_in;

    assign lc      = {1'b0, r_node, 1'b1};
    assign rc      = {1'b0, r_node, 1'b0} + CH_W'(2);
    assign len_ext = CH_W'(r_len);
    assign lc_in   = (lc < len_ext);
    assign rc_in   = (rc < len_ext);

    assign cmp_a = (r_state == ST_KR) ? r_ckey : r_pkey;
    assign cmp_b = (r_state == ST_KR) ? r_key_rd : r_ckey;

    kwm_key_cmp u_cmp (
        .i_a       (cmp_a),
        .i_b       (cmp_b),
        .o_greater (cmp_gt)
    );

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_rd <= r_slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[key_waddr] <= key_wdata;
        end
        r_key_rd <= r_key_mem[key_raddr];
    end

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_node     = r_node;
        n_bld      = r_bld;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_op       = r_op;
        n_src      = r_src;
        n_key      = r_key;
        n_psrc     = r_psrc;
        n_pkey     = r_pkey;
        n_lsrc     = r_lsrc;
        n_rsrc     = r_rsrc;
        n_csrc     = r_csrc;
        n_ckey     = r_ckey;
        n_cidx     = r_cidx;
        n_tsrc     = r_tsrc;
        n_omin     = r_omin;
        n_okey     = r_okey;
        n_ocnt     = r_ocnt;
        n_oempty   = r_oempty;
        slot_we    = 1'b0;
        slot_waddr = r_node;
        slot_wdata = r_psrc;
        slot_raddr = '0;
        key_we     = 1'b0;
        key_waddr  = r_src;
        key_wdata  = r_key;
        key_raddr  = r_tsrc;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_op           = i_in.op;
                    n_src          = i_in.source_id;
                    n_key.ref_id   = i_in.ref_id;
                    n_key.position = i_in.position;
                    n_state        = ST_DISP;
                end
            end
            ST_DISP: begin
                n_node  = '0;
                n_state = ST_TOP0;
                unique case (r_op)
                    kwm_pkg::OP_LOAD: begin
                        if (r_len < CNT_W'(MAX_SOURCES)) begin
                            slot_we    = 1'b1;
                            slot_waddr = IDX_W'(r_len);
                            slot_wdata = r_src;
                            key_we     = 1'b1;
                            n_len      = r_len + CNT_W'(1);
                        end
                    end
                    kwm_pkg::OP_BUILD: begin
                        if (r_len >= CNT_W'(2)) begin
                            n_bld   = IDX_W'((r_len >> 1) - CNT_W'(1));
                            n_node  = IDX_W'((r_len >> 1) - CNT_W'(1));
                            n_state = ST_PLD0;
                        end
                    end
                    kwm_pkg::OP_REPLACE: begin
                        if (r_len != '0) begin
                            slot_raddr = '0;
                            n_state    = ST_REPL1;
                        end
                    end
                    default: begin
                        if (r_len != '0) begin
                            slot_raddr = IDX_W'(r_len - CNT_W'(1));
                            n_len      = r_len - CNT_W'(1);
                            n_state    = ST_PLD1;
                        end
                    end
                endcase
            end
            ST_PLD0: begin
                slot_raddr = r_node;
                n_state    = ST_PLD1;
            end
            ST_PLD1: begin
                n_psrc    = r_slot_rd;
                key_raddr = r_slot_rd;
                n_state   = ST_PLD2;
            end
            ST_PLD2: begin
                n_pkey  = r_key_rd;
                n_state = ST_SL;
            end
            ST_REPL1: begin
                n_psrc    = r_slot_rd;
                key_we    = 1'b1;
                key_waddr = r_slot_rd;
                n_pkey    = r_key;
                n_state   = ST_SL;
            end
            ST_SL: begin
                if (lc_in) begin
                    slot_raddr = IDX_W'(lc);
                    n_state    = ST_SR;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SR: begin
                n_lsrc    = r_slot_rd;
                key_raddr = r_slot_rd;
                if (rc_in) begin
                    slot_raddr = IDX_W'(rc);
                end
                n_state = ST_KL;
            end
            ST_KL: begin
                n_ckey = r_key_rd;
                n_csrc = r_lsrc;
                n_cidx = IDX_W'(lc);
                if (rc_in) begin
                    n_rsrc    = r_slot_rd;
                    key_raddr = r_slot_rd;
                    n_state   = ST_KR;
                end else begin
                    n_state = ST_CP;
                end
            end
            ST_KR: begin
                if (cmp_gt) begin
                    n_ckey = r_key_rd;
                    n_csrc = r_rsrc;
                    n_cidx = IDX_W'(rc);
                end
                n_state = ST_CP;
            end
            ST_CP: begin
                if (cmp_gt) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_node;
                    slot_wdata = r_csrc;
                    n_node     = r_cidx;
                    n_state    = ST_SL;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                slot_we    = 1'b1;
                slot_waddr = r_node;
                slot_wdata = r_psrc;
                if ((r_op == kwm_pkg::OP_BUILD) && (r_bld != '0)) begin
                    n_bld   = r_bld - IDX_W'(1);
                    n_node  = r_bld - IDX_W'(1);
                    n_state = ST_PLD0;
                end else begin
                    n_state = ST_TOP0;
                end
            end
            ST_TOP0: begin
                slot_raddr = '0;
                n_state    = ST_TOP1;
            end
            ST_TOP1: begin
                n_tsrc    = r_slot_rd;
                key_raddr = r_slot_rd;
                n_state   = ST_TOP2;
            end
            ST_TOP2: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_ocnt   = r_len;
                    if (r_len == '0) begin
                        n_omin   = '0;
                        n_okey   = '0;
                        n_oempty = 1'b1;
                    end else begin
                        n_omin   = r_tsrc;
                        n_okey   = r_key_rd;
                        n_oempty = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= '0;
            r_node   <= '0;
            r_bld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_node   <= n_node;
            r_bld    <= n_bld;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_src    <= n_src;
        r_key    <= n_key;
        r_psrc   <= n_psrc;
        r_pkey   <= n_pkey;
        r_lsrc   <= n_lsrc;
        r_rsrc   <= n_rsrc;
        r_csrc   <= n_csrc;
        r_ckey   <= n_ckey;
        r_cidx   <= n_cidx;
        r_tsrc   <= n_tsrc;
        r_omin   <= n_omin;
        r_okey   <= n_okey;
        r_ocnt   <= n_ocnt;
        r_oempty <= n_oempty;
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.min_source   = r_omin;
    assign o_out.min_ref_id   = r_okey.ref_id;
    assign o_out.min_position = r_okey.position;
    assign o_out.entry_count  = r_ocnt;
    assign o_out.is_empty     = r_oempty;

    `KWM_ASSERT(a_len_bound, (r_len <= CNT_W'(MAX_SOURCES)), "heap length above capacity")
    `KWM_ASSERT(a_empty_count, (o_out.valid && o_out.is_empty) |-> (o_out.entry_count == '0), "empty flag with non-zero count")
    `KWM_ASSERT(a_node_in_heap, ((r_state == ST_SL) && (r_len != '0)) |-> (CH_W'(r_node) < len_ext), "sift node outside heap")
    `KWM_ASSERT(a_child_below, (r_state == ST_CP) |-> (r_cidx > r_node), "picked child not below node")
    `KWM_ASSERT(a_load_grows, ((r_state == ST_DISP) && (r_op == kwm_pkg::OP_LOAD) && (r_len < CNT_W'(MAX_SOURCES))) |=> (r_len == $past(r_len) + CNT_W'(1)), "load did not grow heap")

endmodule

`default_nettype wire

[tb/tb_kway_merge_min_heap.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_kway_merge_min_heap
// Drives heap commands into the merge heap and checks every returned heap
// top against a behavioural heap held in a scoreboard. A directed opening
// covers empty-heap commands, key extremes, ties and repeated source
// numbers. Random load/build/drain sequences with noise follow, under
// random idling on both channels, apart from a quiet stretch.
// ---------------------------------------------------------------------------
module tb_kway_merge_min_heap;
    import kwm_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PERCENT  = 35;

    typedef logic signed [31:0] t_word;

    localparam t_word KEY_MAX      = 32'sh7fff_ffff;
    localparam t_word KEY_UNMAPPED = -32'sd1;

    typedef struct packed {
        t_src                  src;
        t_word                 ref_id;
        t_word                 position;
        logic [KWM_CNT_W-1:0]  count;
        logic                  empty;
    } t_heap_view;

    class merge_heap_tracker;
        t_src        slots [KWM_MAX_SOURCES];
        t_key        keys [SOURCE_IDS];
        int unsigned fill;
        int unsigned failures;
        t_heap_view  expected_tops[$];

        function new();
            fill     = 0;
            failures = 0;
        endfunction

        function bit heavier(t_src a, t_src b);
            if (keys[a].ref_id != keys[b].ref_id) begin
                return keys[a].ref_id > keys[b].ref_id;
            end
            return keys[a].position > keys[b].position;
        endfunction

        function void sift_down(int unsigned node);
            int unsigned lc;
            int unsigned pick;
            t_src        held;
            while (node < fill) begin
                lc   = 2 * node + 1;
                pick = node;
                if (lc + 1 < fill) begin
                    pick = heavier(slots[lc], slots[lc + 1]) ? lc + 1 : lc;
                end else if (lc < fill) begin
                    pick = lc;
                end
                if (pick == node || !heavier(slots[node], slots[pick])) begin
                    return;
                end
                held        = slots[node];
                slots[node] = slots[pick];
                slots[pick] = held;
                node        = pick;
            end
        endfunction

        function void note_command(logic [OP_W-1:0] op, t_src src, t_word ref_id,
                                   t_word position);
            t_heap_view  view;
            int unsigned i;
            case (op)
                OP_LOAD: begin
                    if (fill < KWM_MAX_SOURCES) begin
                        slots[fill]         = src;
                        keys[src].ref_id    = ref_id;
                        keys[src].position  = position;
                        fill++;
                    end
                end
                OP_BUILD: begin
                    for (i = fill / 2; i > 0; i--) begin
                        sift_down(i - 1);
                    end
                end
                OP_REPLACE: begin
                    if (fill > 0) begin
                        keys[slots[0]].ref_id   = ref_id;
                        keys[slots[0]].position = position;
                        sift_down(0);
                    end
                end
                default: begin
                    if (fill > 0) begin
                        slots[0] = slots[fill - 1];
                        fill--;
                        sift_down(0);
                    end
                end
            endcase
            view       = '0;
            view.count = KWM_CNT_W'(fill);
            view.empty = (fill == 0);
            if (fill != 0) begin
                view.src      = slots[0];
                view.ref_id   = keys[slots[0]].ref_id;
                view.position = keys[slots[0]].position;
            end
            expected_tops.push_back(view);
        endfunction

        function void check_top(t_heap_view got);
            t_heap_view want;
            if (expected_tops.size() == 0) begin
                $error("unexpected result: min_source %0d entry_count %0d",
                       got.src, got.count);
                failures++;
                return;
            end
            want = expected_tops.pop_front();
            if (got.src !== want.src) begin
                $error("min_source: expected %0d, actual %0d", want.src, got.src);
                failures++;
            end
            if (got.ref_id !== want.ref_id) begin
                $error("min_ref_id: expected %0d, actual %0d", want.ref_id, got.ref_id);
                failures++;
            end
            if (got.position !== want.position) begin
                $error("min_position: expected %0d, actual %0d",
                       want.position, got.position);
                failures++;
            end
            if (got.count !== want.count) begin
                $error("entry_count: expected %0d, actual %0d", want.count, got.count);
                failures++;
            end
            if (got.empty !== want.empty) begin
                $error("is_empty: expected %0d, actual %0d", want.empty, got.empty);
                failures++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    bit                quiet;
    int unsigned       cycle_count = 0;
    int unsigned       applied_items;
    merge_heap_tracker tracker;

    kwm_in_if  in_if ();
    kwm_out_if out_if ();

    kway_merge_min_heap DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_kway_merge_min_heap failed");
        $finish;
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            tracker.check_top('{out_if.min_source, out_if.min_ref_id, out_if.min_position,
                                out_if.entry_count, out_if.is_empty});
        end
    end

    function automatic t_word rand_key_part();
        case ($urandom_range(9))
            0:       return KEY_UNMAPPED;
            1:       return KEY_MAX;
            2, 3, 4, 5, 6: return t_word'($urandom_range(4)) - 1;
            default: return t_word'($urandom() & 32'h7fff_ffff);
        endcase
    endfunction

    task automatic send_command(logic [OP_W-1:0] op, t_src src, t_word ref_id,
                                t_word position);
        bit ignored;
        ignored = (op == OP_LOAD && tracker.fill >= KWM_MAX_SOURCES) ||
                  ((op == OP_REPLACE || op == OP_REMOVE) && tracker.fill == 0);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.source_id <= src;
        in_if.ref_id    <= ref_id;
        in_if.position  <= position;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_command(op, src, ref_id, position);
        if (!ignored) begin
            applied_items++;
        end
    endtask

    task automatic load_random();
        send_command(OP_LOAD, t_src'($urandom_range(SOURCE_IDS - 1)), rand_key_part(),
                     rand_key_part());
    endtask

    initial begin
        int unsigned seq_count;
        int unsigned n;
        int unsigned r;
        tracker          = new();
        quiet            = 1'b0;
        applied_items    = 0;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.op        <= OP_LOAD;
        in_if.source_id <= '0;
        in_if.ref_id    <= '0;
        in_if.position  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty heap, single entry, key extremes, ties, repeated source
        send_command(OP_REMOVE, 5'd3, 32'sd5, 32'sd5);
        send_command(OP_REPLACE, 5'd0, 32'sd7, 32'sd7);
        send_command(OP_BUILD, 5'd0, 32'sd0, 32'sd0);
        send_command(OP_LOAD, 5'd31, KEY_MAX, KEY_MAX);
        send_command(OP_BUILD, 5'd0, 32'sd0, 32'sd0);
        send_command(OP_REPLACE, 5'd9, KEY_UNMAPPED, KEY_UNMAPPED);
        send_command(OP_LOAD, 5'd0, KEY_UNMAPPED, KEY_UNMAPPED);
        send_command(OP_LOAD, 5'd5, KEY_UNMAPPED, KEY_MAX);
        send_command(OP_LOAD, 5'd12, 32'sd0, KEY_UNMAPPED);
        send_command(OP_LOAD, 5'd7, KEY_UNMAPPED, KEY_UNMAPPED);
        send_command(OP_LOAD, 5'd5, 32'sd3, 32'sd0);
        send_command(OP_BUILD, 5'd0, 32'sd0, 32'sd0);
        send_command(OP_REPLACE, 5'd0, KEY_MAX, KEY_UNMAPPED);
        send_command(OP_REPLACE, 5'd0, KEY_UNMAPPED, 32'sd0);
        send_command(OP_LOAD, 5'd20, 32'sd1, 32'sd2);
        repeat (7) send_command(OP_REMOVE, 5'd31, KEY_MAX, KEY_MAX);

        applied_items = 0;
        seq_count     = 0;
        while (applied_items < RANDOM_ITEMS) begin
            seq_count++;
            quiet = (applied_items >= 350 && applied_items < 470);
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_command(OP_W'($urandom_range(3)),
                                 t_src'($urandom_range(SOURCE_IDS - 1)),
                                 rand_key_part(), rand_key_part());
                end
            end else begin
                // overfill the heap now and then
                if (seq_count == 1 || $urandom_range(7) == 0) begin
                    n = $urandom_range(30, 35);
                end else begin
                    n = $urandom_range(1, 8);
                end
                repeat (n) load_random();
                if ($urandom_range(9) != 0) begin
                    send_command(OP_BUILD, t_src'($urandom_range(SOURCE_IDS - 1)),
                                 rand_key_part(), rand_key_part());
                end
                while (tracker.fill > 0) begin
                    r = $urandom_range(99);
                    if (r < 45) begin
                        send_command(OP_REPLACE, t_src'($urandom_range(SOURCE_IDS - 1)),
                                     rand_key_part(), rand_key_part());
                    end else if (r < 90) begin
                        send_command(OP_REMOVE, t_src'($urandom_range(SOURCE_IDS - 1)),
                                     rand_key_part(), rand_key_part());
                    end else if (r < 96) begin
                        load_random();
                    end else begin
                        send_command(OP_BUILD, t_src'($urandom_range(SOURCE_IDS - 1)),
                                     rand_key_part(), rand_key_part());
                    end
                    // drop the sequence part way through
                    if ($urandom_range(49) == 0) begin
                        break;
                    end
                end
            end
        end
        in_if.valid <= 1'b0;
        quiet        = 1'b0;

        while (tracker.expected_tops.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0) begin
            $display("tb_kway_merge_min_heap passed");
        end else begin
            $display("tb_kway_merge_min_heap failed");
        end
        $finish;
    end

endmodule
